// ===== src/mma_pkg.sv =====
package mma_pkg;

  localparam int unsigned CHANNELS_DEF    = 3;
  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // fixed field widths of the channel tag and the average
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned AVG_W  = 12;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_e;

endpackage

// ===== src/mma_in_if.sv =====
interface mma_in_if #(
  parameter int unsigned SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [mma_pkg::CHAN_W-1:0]  channel;
  logic [SAMPLE_BITS-1:0]      sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== src/mma_out_if.sv =====
interface mma_out_if;
  logic                        valid;
  logic                        ready;
  logic [mma_pkg::CHAN_W-1:0]  out_channel;
  logic [mma_pkg::AVG_W-1:0]   average;

  modport source (output valid, output out_channel, output average, input ready);
  modport sink   (input valid, input out_channel, input average, output ready);
endinterface

// ===== src/mma_div.sv =====
module mma_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle shifted in at the bottom
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = num_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> den_q != '0)
    else $error("division by zero");

  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) |-> rem_q < den_q)
    else $error("partial remainder not reduced");

endmodule

// ===== src/multichannel_moving_average.sv =====
// Moving average over the last WINDOW samples, kept separately per channel.
// Input channel in_i carries channel and sample; output channel out_o carries
// out_channel and average, one result beat for each input beat, in order.
// Both use valid/ready; a beat moves when both are high.
// A sample passes these steps from acceptance to out_o.valid: the window
// store is read at the accepting edge, then the sum is updated, the
// bit-serial divider (numerator SAMPLE_BITS + clog2(WINDOW+1) bits) runs
// and the output register is loaded. The divider handles one sample at a
// time, and a new sample is taken only after the control returns to idle.
// A channel tag of CHANNELS or more leaves all state alone and gives an
// average of zero.
// Reset clears every sum, fill count and write position; the window store
// is not cleared, an entry is only read back after its channel has filled.
// When out_o is stalled the result waits in the output register and the
// next sample is still accepted and processed; it then waits in the final
// state until the output register is free.
module multichannel_moving_average #(
  parameter int unsigned CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW      = mma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mma_in_if.sink     in_i,
  mma_out_if.source  out_o
);

  localparam int unsigned FILL_W   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W    = SAMPLE_BITS + FILL_W;
  localparam int unsigned POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEPTH    = CHANNELS * WINDOW;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mma_pkg::state_e state_q, state_d;

  logic [mma_pkg::CHAN_W-1:0] chan_q;
  logic [SAMPLE_BITS-1:0]     smp_q;
  logic                       hit_q;
  logic [ADDR_W-1:0]          addr_q;
  logic [SAMPLE_BITS-1:0]     rd_q;

  logic [SUM_W-1:0]  sum_q  [CHANNELS];
  logic [FILL_W-1:0] fill_q [CHANNELS];
  logic [POS_W-1:0]  pos_q  [CHANNELS];

  logic [SAMPLE_BITS-1:0] store_mem [DEPTH];

  logic                       out_valid_q, out_valid_d;
  logic [mma_pkg::CHAN_W-1:0] out_chan_q;
  logic [mma_pkg::AVG_W-1:0]  out_avg_q;

  logic                in_acc;
  logic                in_hit;
  logic [CH_IDX_W-1:0] in_idx;
  logic [ADDR_W-1:0]   in_addr;
  logic [CH_IDX_W-1:0] cur_idx;
  logic                full;
  logic [SUM_W-1:0]    sum_new;
  logic [FILL_W-1:0]   fill_new;
  logic [POS_W-1:0]    pos_new;
  logic                upd;
  logic                div_start;
  logic [SUM_W-1:0]    div_num;
  logic [FILL_W-1:0]   div_den;
  logic                div_done;
  logic [SUM_W-1:0]    div_quot;
  logic                out_load;

  assign in_i.ready = (state_q == mma_pkg::S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign in_hit     = int'(in_i.channel) < int'(CHANNELS);
  assign in_idx     = in_hit ? CH_IDX_W'(in_i.channel) : '0;
  assign in_addr    = ADDR_W'(in_idx) * ADDR_W'(WINDOW) + ADDR_W'(pos_q[in_idx]);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chan_q <= in_i.channel;
      smp_q  <= in_i.sample;
      hit_q  <= in_hit;
      addr_q <= in_addr;
    end
  end

  // window store, read at acceptance and written back in the update cycle
  always_ff @(posedge clk_i) begin
    if (upd) begin
      store_mem[addr_q] <= smp_q;
    end
    if (in_acc) begin
      rd_q <= store_mem[in_addr];
    end
  end

  assign cur_idx  = hit_q ? CH_IDX_W'(chan_q) : '0;
  assign full     = fill_q[cur_idx] == FILL_W'(WINDOW);
  assign fill_new = full ? fill_q[cur_idx] : fill_q[cur_idx] + FILL_W'(1);
  assign pos_new  = (pos_q[cur_idx] == POS_W'(WINDOW - 1)) ? '0
                                                           : pos_q[cur_idx] + POS_W'(1);
  // oldest sample leaves the sum once the window is full
  assign sum_new  = full ? sum_q[cur_idx] - SUM_W'(rd_q) + SUM_W'(smp_q)
                         : sum_q[cur_idx] + SUM_W'(smp_q);

  assign div_start = (state_q == mma_pkg::S_UPDATE);
  assign upd       = div_start & hit_q;
  assign div_num   = hit_q ? sum_new : '0;
  assign div_den   = hit_q ? fill_new : FILL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        sum_q[i]  <= '0;
        fill_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else if (upd) begin
      sum_q[cur_idx]  <= sum_new;
      fill_q[cur_idx] <= fill_new;
      pos_q[cur_idx]  <= pos_new;
    end
  end

  mma_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_o.ready;
    case (state_q)
      mma_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = mma_pkg::S_UPDATE;
        end
      end
      mma_pkg::S_UPDATE: begin
        state_d = mma_pkg::S_DIV;
      end
      mma_pkg::S_DIV: begin
        if (div_done) begin
          state_d = mma_pkg::S_DONE;
        end
      end
      mma_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = mma_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mma_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mma_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= chan_q;
      out_avg_q  <= mma_pkg::AVG_W'(div_quot);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_chan_q;
  assign out_o.average     = out_avg_q;

  a_accept_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mma_pkg::S_UPDATE)
    else $error("accepted beat not processed");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pos_q[0]) < int'(WINDOW))
    else $error("write position beyond window");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_o.ready)
    else $error("output register overwritten");

endmodule
